// ===== src/zsc_pkg.sv =====
`default_nettype none
package zsc_pkg;

	localparam int MAX_VALUES = 16;
	localparam int LEN_W      = 32;
	localparam int DATA_W     = 30;
	localparam int VAL_W      = 16;
	localparam int DIM        = 2 * MAX_VALUES;
	localparam int IDX_W      = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int ADDR_W     = $clog2(DIM * DIM);
	localparam int MV_W       = $clog2(MAX_VALUES + 1);
	localparam int S_W        = $clog2(DIM + 1);
	localparam int CNT_W      = $clog2(DATA_W);
	localparam logic [DATA_W-1:0] MOD_RESET = DATA_W'(1000000007);

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_WIDE  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_SMALL,
		E_INIT,
		E_BIT,
		E_RD_A,
		E_RD_B,
		E_MUL,
		E_WAIT,
		E_COPY,
		E_COPY_END,
		E_FIN_RD,
		E_FIN_MUL,
		E_FIN_WAIT,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] r;
	} mm_rsp_t;

	// flat address of a matrix entry
	function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return ADDR_W'(int'(r) * DIM + int'(c));
	endfunction

endpackage
`default_nettype wire

// ===== src/zigzag_sequence_counter.sv =====
// error ranges go straight to the result and lengths up to two take a single product;
// longer lengths first load the start matrices, then run the s x s matrix products
// (s = 2*(high-low+1), up to two products per exponent bit) and the final sum,
// all on one bit-serial modular multiplier
// throughput: one item at a time; the next item is taken once the result is in the output reg
// reset: arst_n clears control and sets the modulus to 1000000007; matrices need no clearing
`default_nettype none
module zigzag_sequence_counter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // seq_length[31:0], range_low[47:32], range_high[63:48]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // count[29:0], error_code[31:30]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [29:0] cfg_data
);

	logic [zsc_pkg::DATA_W-1:0] modulus_q;
	logic                       res_valid, res_ready;
	logic [zsc_pkg::DATA_W-1:0] res_count;
	zsc_pkg::err_t              res_err;
	logic                       out_valid_q;
	logic [31:0]                out_data_q;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= zsc_pkg::MOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	zsc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.modulus    (modulus_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.seq_length (s_tdata[31:0]),
		.range_low  (s_tdata[47:32]),
		.range_high (s_tdata[63:48]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_count  (res_count),
		.res_err    (res_err)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {res_err, res_count};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== src/zsc_mulmod.sv =====
`default_nettype none
module zsc_mulmod (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [zsc_pkg::DATA_W-1:0] modulus,
	input  wire zsc_pkg::mm_req_t          req,
	output zsc_pkg::mm_rsp_t               rsp
);

	logic [zsc_pkg::DATA_W-1:0] r_q, a_q, b_q;
	logic [zsc_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q, done_q;
	logic [zsc_pkg::DATA_W:0]   t1, t2, m_ext;

	// one bit of the multiplier per cycle, msb first: r = 2r + bit*a mod m
	always_comb begin
		m_ext = {1'b0, modulus};
		t1 = {r_q, 1'b0};
		if (t1 >= m_ext) begin
			t1 = t1 - m_ext;
		end
		t2 = t1 + (b_q[zsc_pkg::DATA_W-1] ? {1'b0, a_q} : '0);
		if (t2 >= m_ext) begin
			t2 = t2 - m_ext;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operands and partial result
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			cnt_q <= zsc_pkg::CNT_W'(zsc_pkg::DATA_W - 1);
		end else if (busy_q) begin
			r_q   <= t2[zsc_pkg::DATA_W-1:0];
			b_q   <= {b_q[zsc_pkg::DATA_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// a zero modulus reduces everything to zero
	assign rsp.done = done_q;
	assign rsp.r    = (modulus == '0) ? '0 : r_q;

endmodule
`default_nettype wire

// ===== src/zsc_engine.sv =====
`default_nettype none
module zsc_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [zsc_pkg::DATA_W-1:0] modulus,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [zsc_pkg::LEN_W-1:0]  seq_length,
	input  wire logic [zsc_pkg::VAL_W-1:0]  range_low,
	input  wire logic [zsc_pkg::VAL_W-1:0]  range_high,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output logic [zsc_pkg::DATA_W-1:0]      res_count,
	output zsc_pkg::err_t                  res_err
);

	localparam int DW = zsc_pkg::DATA_W;
	localparam int IW = zsc_pkg::IDX_W;
	localparam int AW = zsc_pkg::ADDR_W;
	localparam int NE = zsc_pkg::DIM * zsc_pkg::DIM;
	localparam int PW = 2 * zsc_pkg::MV_W;

	zsc_pkg::eng_state_t state_q, state_d;
	zsc_pkg::mm_req_t    mm_req;
	zsc_pkg::mm_rsp_t    mm_rsp;
	zsc_pkg::err_t       err_q;

	logic [zsc_pkg::LEN_W-1:0] e_q;
	logic [zsc_pkg::MV_W-1:0]  m_q;
	logic [zsc_pkg::S_W-1:0]   s_q, s_m1;
	logic [IW-1:0]             i_q, j_q, k_q;
	logic                      dst_acc_q, phase_sq_q;
	logic [DW-1:0]             a_q, sum_q, count_q;
	logic                      cp_valid_s1;
	logic [AW-1:0]             cp_addr_s1;

	logic [DW-1:0] acc_mem [NE];
	logic [DW-1:0] sq_mem  [NE];
	logic [DW-1:0] scr_mem [NE];
	logic [DW-1:0] acc_rd_q, sq_rd_q, scr_rd_q;

	logic              accept, one, last_i, last_j, last_k;
	logic [zsc_pkg::VAL_W:0] m_full;
	logic              empty, wide, short_len;
	logic [DW-1:0]     small_x, sum_new, init_acc, init_sq, sv_b;
	logic [DW:0]       add_t;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              acc_we, sq_we, scr_we;
	logic [DW-1:0]     acc_wd, sq_wd;
	logic [zsc_pkg::MV_W-1:0] m_in;
	int                ii, jj, mm;

	zsc_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus),
		.req     (mm_req),
		.rsp     (mm_rsp)
	);

	// query decode
	always_comb begin
		accept    = in_valid && in_ready;
		one       = (modulus > DW'(1));
		m_full    = {1'b0, range_high} - {1'b0, range_low} + 1'b1;
		empty     = range_high < range_low;
		wide      = m_full > (zsc_pkg::VAL_W + 1)'(zsc_pkg::MAX_VALUES);
		short_len = seq_length < zsc_pkg::LEN_W'(3);
		m_in      = m_full[zsc_pkg::MV_W-1:0];
		if (seq_length == '0) begin
			small_x = DW'(1);
		end else if (seq_length == zsc_pkg::LEN_W'(1)) begin
			small_x = DW'(m_in);
		end else begin
			small_x = DW'(PW'(m_in) * (PW'(m_in) - PW'(1)));
		end
	end

	// loop bounds
	always_comb begin
		s_m1   = s_q - 1'b1;
		last_i = i_q == s_m1[IW-1:0];
		last_j = j_q == s_m1[IW-1:0];
		last_k = k_q == s_m1[IW-1:0];
	end

	// modular add of the product into the running sum
	always_comb begin
		add_t = {1'b0, (state_q == zsc_pkg::E_FIN_WAIT) ? count_q : sum_q} + {1'b0, mm_rsp.r};
		if (add_t >= {1'b0, modulus}) begin
			add_t = add_t - {1'b0, modulus};
		end
		sum_new = add_t[DW-1:0];
	end

	// start entries and start vector from the index pair
	always_comb begin
		ii = int'(i_q);
		jj = int'(j_q);
		mm = int'(m_q);
		init_acc = (ii == jj) ? DW'(one) : '0;
		init_sq  = '0;
		if (ii < mm) begin
			if (jj >= mm && (jj - mm) < ii) begin
				init_sq = DW'(one);
			end
		end else if (jj < mm && jj > (ii - mm)) begin
			init_sq = DW'(one);
		end
		sv_b = (jj < mm) ? DW'(jj) : DW'(2 * mm - 1 - jj);
	end

	// shared read address and write port selection
	always_comb begin
		case (state_q)
			zsc_pkg::E_RD_A: rd_addr = zsc_pkg::mat_addr(i_q, k_q);
			zsc_pkg::E_RD_B: rd_addr = zsc_pkg::mat_addr(k_q, j_q);
			default:         rd_addr = zsc_pkg::mat_addr(i_q, j_q);
		endcase
		if (state_q == zsc_pkg::E_INIT) begin
			wr_addr = zsc_pkg::mat_addr(i_q, j_q);
			acc_we  = 1'b1;
			sq_we   = 1'b1;
			acc_wd  = init_acc;
			sq_wd   = init_sq;
		end else begin
			wr_addr = cp_addr_s1;
			acc_we  = cp_valid_s1 && dst_acc_q;
			sq_we   = cp_valid_s1 && !dst_acc_q;
			acc_wd  = scr_rd_q;
			sq_wd   = scr_rd_q;
		end
		scr_we = (state_q == zsc_pkg::E_WAIT) && mm_rsp.done && last_k;
	end

	// working matrices
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[wr_addr] <= acc_wd;
		end
		acc_rd_q <= acc_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sq_we) begin
			sq_mem[wr_addr] <= sq_wd;
		end
		sq_rd_q <= sq_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[zsc_pkg::mat_addr(i_q, j_q)] <= sum_new;
		end
		scr_rd_q <= scr_mem[rd_addr];
	end

	// multiplier requests
	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = DW'(one);
		mm_req.b     = small_x;
		case (state_q)
			zsc_pkg::E_IDLE: begin
				mm_req.start = accept && !empty && !wide && short_len;
			end
			zsc_pkg::E_MUL: begin
				mm_req.start = 1'b1;
				mm_req.a     = a_q;
				mm_req.b     = sq_rd_q;
			end
			zsc_pkg::E_FIN_MUL: begin
				mm_req.start = 1'b1;
				mm_req.a     = acc_rd_q;
				mm_req.b     = sv_b;
			end
			default: ;
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			zsc_pkg::E_IDLE: begin
				if (accept) begin
					if (empty || wide) begin
						state_d = zsc_pkg::E_DONE;
					end else if (short_len) begin
						state_d = zsc_pkg::E_SMALL;
					end else begin
						state_d = zsc_pkg::E_INIT;
					end
				end
			end
			zsc_pkg::E_SMALL: begin
				if (mm_rsp.done) begin
					state_d = zsc_pkg::E_DONE;
				end
			end
			zsc_pkg::E_INIT: begin
				if (last_i && last_j) begin
					state_d = zsc_pkg::E_BIT;
				end
			end
			zsc_pkg::E_BIT: begin
				if (e_q == '0) begin
					state_d = zsc_pkg::E_FIN_RD;
				end else if (e_q[0] && !phase_sq_q) begin
					state_d = zsc_pkg::E_RD_A;
				end else if (e_q[zsc_pkg::LEN_W-1:1] == '0) begin
					state_d = zsc_pkg::E_FIN_RD;
				end else begin
					state_d = zsc_pkg::E_RD_A;
				end
			end
			zsc_pkg::E_RD_A: state_d = zsc_pkg::E_RD_B;
			zsc_pkg::E_RD_B: state_d = zsc_pkg::E_MUL;
			zsc_pkg::E_MUL:  state_d = zsc_pkg::E_WAIT;
			zsc_pkg::E_WAIT: begin
				if (mm_rsp.done) begin
					state_d = (last_k && last_j && last_i) ? zsc_pkg::E_COPY
					                                       : zsc_pkg::E_RD_A;
				end
			end
			zsc_pkg::E_COPY: begin
				if (last_i && last_j) begin
					state_d = zsc_pkg::E_COPY_END;
				end
			end
			zsc_pkg::E_COPY_END: state_d = zsc_pkg::E_BIT;
			zsc_pkg::E_FIN_RD:   state_d = zsc_pkg::E_FIN_MUL;
			zsc_pkg::E_FIN_MUL:  state_d = zsc_pkg::E_FIN_WAIT;
			zsc_pkg::E_FIN_WAIT: begin
				if (mm_rsp.done) begin
					state_d = (last_i && last_j) ? zsc_pkg::E_DONE : zsc_pkg::E_FIN_RD;
				end
			end
			zsc_pkg::E_DONE: begin
				if (res_ready) begin
					state_d = zsc_pkg::E_IDLE;
				end
			end
			default: state_d = zsc_pkg::E_IDLE;
		endcase
	end

	// state register and copy pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zsc_pkg::E_IDLE;
			cp_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			cp_valid_s1 <= (state_q == zsc_pkg::E_COPY);
		end
	end

	// loop counters and working registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= zsc_pkg::mat_addr(i_q, j_q);
		case (state_q)
			zsc_pkg::E_IDLE: begin
				i_q        <= '0;
				j_q        <= '0;
				k_q        <= '0;
				sum_q      <= '0;
				phase_sq_q <= 1'b0;
				m_q        <= m_in;
				s_q        <= zsc_pkg::S_W'({m_in, 1'b0});
				e_q        <= seq_length - zsc_pkg::LEN_W'(2);
				count_q    <= '0;
				err_q      <= empty ? zsc_pkg::ERR_EMPTY
				            : (wide ? zsc_pkg::ERR_WIDE : zsc_pkg::ERR_OK);
			end
			zsc_pkg::E_SMALL: begin
				if (mm_rsp.done) begin
					count_q <= mm_rsp.r;
				end
			end
			zsc_pkg::E_INIT, zsc_pkg::E_COPY: begin
				if (last_j) begin
					j_q <= '0;
					i_q <= last_i ? '0 : i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			zsc_pkg::E_BIT: begin
				dst_acc_q <= e_q[0] && !phase_sq_q;
				i_q       <= '0;
				j_q       <= '0;
				k_q       <= '0;
				sum_q     <= '0;
			end
			zsc_pkg::E_RD_B: begin
				a_q <= dst_acc_q ? acc_rd_q : sq_rd_q;
			end
			zsc_pkg::E_WAIT: begin
				if (mm_rsp.done) begin
					if (last_k) begin
						k_q   <= '0;
						sum_q <= '0;
						if (last_j) begin
							j_q <= '0;
							i_q <= last_i ? '0 : i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q   <= k_q + 1'b1;
						sum_q <= sum_new;
					end
				end
			end
			zsc_pkg::E_COPY_END: begin
				if (dst_acc_q) begin
					phase_sq_q <= 1'b1;
				end else begin
					phase_sq_q <= 1'b0;
					e_q        <= e_q >> 1;
				end
			end
			zsc_pkg::E_FIN_WAIT: begin
				if (mm_rsp.done) begin
					count_q <= sum_new;
					if (last_j) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == zsc_pkg::E_IDLE);
	assign res_valid = (state_q == zsc_pkg::E_DONE);
	assign res_count = count_q;
	assign res_err   = err_q;

endmodule
`default_nettype wire
